// File: design/assert_macros.svh
// Assertion macros used by the sequencer RTL (i2cseq_step).
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Implication checked on every rising clock edge outside of reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/i2cseq_pkg.sv
// Types and constants of the I2C register sequencer.
// No dependencies; used by every module of the block.
package i2cseq_pkg;

    localparam int MAX_READ_BYTES_DEF = 64;
    localparam int COUNT_W            = 7;
    localparam int POS_W              = 6;
    localparam logic [1:0] WRITE_MAX  = 2'd2;
    localparam int IN_TDATA_W         = 56;
    localparam int OUT_TDATA_W        = 40;

    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_START_WRITE = 2'd1,
        CMD_TX_READY    = 2'd2,
        CMD_RX_BYTE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_SWRX  = 3'd2,
        PH_WDATA = 3'd3,
        PH_RDATA = 3'd4
    } phase_t;

    typedef struct packed {
        cmd_t               command;
        logic [6:0]         slave_address;
        logic [15:0]        register_address;
        logic [COUNT_W-1:0] byte_count;
        logic [15:0]        write_value;
        logic [7:0]         rx_data;
    } item_t;

    typedef struct packed {
        logic             busy_res;
        logic             done_res;
        logic [POS_W-1:0] rx_position;
        logic [7:0]       rx_byte_out;
        logic             rx_valid;
        logic             stop_request;
        logic             repeated_start_rx;
        logic [7:0]       tx_byte;
        logic             tx_valid;
        logic [6:0]       slave_address_out;
        logic             start_transmit;
    } result_t;

endpackage

// File: design/i2cseq_step.sv
// Sequencer state and the per-request decision logic.
// Depends on i2cseq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cseq_step
    import i2cseq_pkg::*;
#(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    output result_t result
);

    localparam logic [7:0] MaxRead = 8'(MAX_READ_BYTES);

    phase_t             phase_reg, phase_next;
    logic [15:0]        reg_addr_reg, reg_addr_next;
    logic               addr_sel_reg, addr_sel_next;
    logic [COUNT_W-1:0] rd_rem_reg, rd_rem_next;
    logic [POS_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [1:0]         wr_rem_reg, wr_rem_next;
    logic               wr_idx_reg, wr_idx_next;
    logic [15:0]        wr_val_reg, wr_val_next;

    logic [COUNT_W-1:0] rd_count_sat;
    logic [1:0]         wr_count_sat;
    logic [COUNT_W-1:0] rd_rem_after;

    assign rd_count_sat = ({1'b0, item.byte_count} > MaxRead) ? MaxRead[COUNT_W-1:0]
                                                              : item.byte_count;
    assign wr_count_sat = (item.byte_count > COUNT_W'(WRITE_MAX)) ? WRITE_MAX
                                                                  : item.byte_count[1:0];
    // Remaining read count once the current received byte is taken.
    assign rd_rem_after = (rd_rem_reg != '0) ? rd_rem_reg - 1'b1 : rd_rem_reg;

    always_comb begin
        phase_next    = phase_reg;
        reg_addr_next = reg_addr_reg;
        addr_sel_next = addr_sel_reg;
        rd_rem_next   = rd_rem_reg;
        rd_idx_next   = rd_idx_reg;
        wr_rem_next   = wr_rem_reg;
        wr_idx_next   = wr_idx_reg;
        wr_val_next   = wr_val_reg;
        unique case (item.command) inside
            CMD_START_READ, CMD_START_WRITE: begin
                // A start always restarts, dropping any running transaction.
                phase_next    = PH_ADDR;
                reg_addr_next = item.register_address;
                addr_sel_next = 1'b0;
                rd_idx_next   = '0;
                wr_idx_next   = 1'b0;
                wr_val_next   = item.write_value;
                if (item.command == CMD_START_READ) begin
                    rd_rem_next = rd_count_sat;
                    wr_rem_next = '0;
                end else begin
                    rd_rem_next = '0;
                    wr_rem_next = wr_count_sat;
                end
            end
            CMD_TX_READY: begin
                unique case (phase_reg)
                    PH_ADDR: begin
                        if (!addr_sel_reg) begin
                            addr_sel_next = 1'b1;
                        end else begin
                            phase_next = (rd_rem_reg != '0) ? PH_SWRX : PH_WDATA;
                        end
                    end
                    PH_SWRX: begin
                        phase_next = PH_RDATA;
                    end
                    PH_WDATA: begin
                        if (wr_rem_reg != '0) begin
                            wr_idx_next = ~wr_idx_reg;
                            wr_rem_next = wr_rem_reg - 1'b1;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_RX_BYTE: begin
                if (phase_reg == PH_RDATA) begin
                    if (rd_rem_reg != '0) begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    rd_rem_next = rd_rem_after;
                    if (rd_rem_after == '0) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result = '0;
        unique case (item.command) inside
            CMD_START_READ, CMD_START_WRITE: begin
                result.start_transmit    = 1'b1;
                result.slave_address_out = item.slave_address;
            end
            CMD_TX_READY: begin
                unique case (phase_reg)
                    PH_ADDR: begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = addr_sel_reg ? reg_addr_reg[7:0]
                                                       : reg_addr_reg[15:8];
                    end
                    PH_SWRX: begin
                        result.repeated_start_rx = 1'b1;
                        // A one-byte read has to ask for the stop right away.
                        result.stop_request = (rd_rem_reg == COUNT_W'(1));
                    end
                    PH_WDATA: begin
                        if (wr_rem_reg != '0) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = wr_idx_reg ? wr_val_reg[7:0] : wr_val_reg[15:8];
                        end else begin
                            result.stop_request = 1'b1;
                            result.done_res     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_RX_BYTE: begin
                if (phase_reg == PH_RDATA) begin
                    if (rd_rem_reg != '0) begin
                        result.rx_valid    = 1'b1;
                        result.rx_byte_out = item.rx_data;
                        result.rx_position = rd_idx_reg;
                    end
                    result.stop_request = (rd_rem_after == COUNT_W'(1));
                    result.done_res     = (rd_rem_after == '0);
                end
            end
            default: ;
        endcase
        result.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            reg_addr_reg <= '0;
            addr_sel_reg <= 1'b0;
            rd_rem_reg   <= '0;
            rd_idx_reg   <= '0;
            wr_rem_reg   <= '0;
            wr_idx_reg   <= 1'b0;
            wr_val_reg   <= '0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            reg_addr_reg <= reg_addr_next;
            addr_sel_reg <= addr_sel_next;
            rd_rem_reg   <= rd_rem_next;
            rd_idx_reg   <= rd_idx_next;
            wr_rem_reg   <= wr_rem_next;
            wr_idx_reg   <= wr_idx_next;
            wr_val_reg   <= wr_val_next;
        end
    end

    `ASSERT_CLKD(a_one_action, aclk, aresetn,
        !step_en || $onehot0({result.start_transmit, result.tx_valid,
                              result.repeated_start_rx, result.rx_valid}),
        "more than one bus action in a result")
    `ASSERT_IMPLIES(a_idle_clear, aclk, aresetn, phase_reg == PH_IDLE,
        rd_rem_reg == '0 && wr_rem_reg == '0, "idle with bytes still pending")
    `ASSERT_IMPLIES(a_wdata_no_read, aclk, aresetn, phase_reg == PH_WDATA,
        rd_rem_reg == '0, "write data phase with a read count")
    `ASSERT_CLKD(a_counts_sat, aclk, aresetn,
        wr_rem_reg <= WRITE_MAX && {1'b0, rd_rem_reg} <= MaxRead,
        "byte count above its saturation limit")

endmodule

// File: design/i2cseq_out_reg.sv
// Result register of the sequencer: holds one result until the receiver takes it.
// Depends on i2cseq_pkg.
module i2cseq_out_reg
    import i2cseq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                result_in,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), data_reg};

endmodule

// File: design/i2c_master_register_sequencer.sv
// Top level of the I2C register sequencer: input register, step logic, result register.
// Depends on i2cseq_pkg, i2cseq_step and i2cseq_out_reg.
//
// Use: each slave-side request is one command for the sequencer: a start of a
// register read or write (with target, register address, count and write value),
// a transmit-ready event or a received-byte event from the bus controller.
// For every request exactly one result leaves on the master side; it tells the
// bus controller what to do next (start, byte to send, repeated start, stop)
// and carries received bytes with their position, plus done and busy flags.
// A request accepted into the input register moves on into the result register,
// where its result shows with m_axis_tvalid high.
// Throughput: one request per cycle while the receiver takes results; the sequencer state is updated in the same
// cycle that a request moves from the input register into the result register.
// When the receiver stalls, the result register holds and the input register
// keeps one more request; s_axis_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both registers and returns the
// sequencer to idle with all counters and saved addresses cleared.
module i2c_master_register_sequencer
    import i2cseq_pkg::*;
#(
    parameter int MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // slave_address, register_address, byte_count, write_value, rx_data, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // start_transmit, slave_address_out, tx_valid, tx_byte, repeated_start_rx,
    // stop_request, rx_valid, rx_byte_out, rx_position, done_res, busy_res, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    advance;
    result_t step_result;

    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.command          <= cmd_t'(s_axis_tuser);
            in_item_reg.slave_address    <= s_axis_tdata[6:0];
            in_item_reg.register_address <= s_axis_tdata[22:7];
            in_item_reg.byte_count       <= s_axis_tdata[29:23];
            in_item_reg.write_value      <= s_axis_tdata[45:30];
            in_item_reg.rx_data          <= s_axis_tdata[53:46];
        end
    end

    i2cseq_step #(
        .MAX_READ_BYTES(MAX_READ_BYTES)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    i2cseq_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .result_in     (step_result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: test/i2c_master_register_sequencer_tb.sv
// Self-checking testbench for the I2C register sequencer: directed and random requests,
// checked result by result against a predictor of the sequencer kept in this file.
// Depends on i2cseq_pkg and i2c_master_register_sequencer.
`timescale 1ns / 100ps

module i2c_master_register_sequencer_tb;
    import i2cseq_pkg::*;

    localparam int READ_LIMIT     = MAX_READ_BYTES_DEF;
    localparam int STALL_LIMIT    = 1000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int REPORT_MAX     = 10;

    typedef struct {
        cmd_t        command;
        logic [6:0]  slave_address;
        logic [15:0] register_address;
        logic [6:0]  byte_count;
        logic [15:0] write_value;
        logic [7:0]  rx_data;
    } seq_req_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // slave_address, register_address, byte_count, write_value, rx_data, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // command
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // start_transmit, slave_address_out, tx_valid, tx_byte, repeated_start_rx,
    // stop_request, rx_valid, rx_byte_out, rx_position, done_res, busy_res, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    i2c_master_register_sequencer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Requests waiting for the driver and bus actions waiting for the monitor.
    seq_req_t pending_reqs[$];
    result_t  bus_actions_due[$];
    seq_req_t req_on_bus;
    seq_req_t req_next;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_req   = 1'b0;
    int hold_off_left  = 0;

    int n_requests  = 0;
    int n_results   = 0;
    int n_failures  = 0;
    int n_starts    = 0;
    int n_rx_bytes  = 0;
    int n_completed = 0;
    int idle_cycles = 0;

    // Predicted sequencer state.
    phase_t      seq_phase      = PH_IDLE;
    logic [15:0] reg_addr_held  = '0;
    logic        addr_low_next  = 1'b0;
    logic [6:0]  bytes_to_read  = '0;
    logic [6:0]  read_pos       = '0;
    logic [1:0]  bytes_to_write = '0;
    logic        write_low_next = 1'b0;
    logic [15:0] payload_held   = '0;

    function automatic result_t predict_bus_action(input seq_req_t r);
        result_t a;
        a = '0;
        if (r.command == CMD_START_READ || r.command == CMD_START_WRITE) begin
            // A start always wins, even over a transaction still in flight.
            seq_phase      = PH_ADDR;
            reg_addr_held  = r.register_address;
            addr_low_next  = 1'b0;
            read_pos       = '0;
            write_low_next = 1'b0;
            payload_held   = r.write_value;
            if (r.command == CMD_START_READ) begin
                bytes_to_read  = (r.byte_count > READ_LIMIT) ? 7'(READ_LIMIT) : r.byte_count;
                bytes_to_write = '0;
            end else begin
                bytes_to_read  = '0;
                bytes_to_write = (r.byte_count > WRITE_MAX) ? WRITE_MAX : r.byte_count[1:0];
            end
            a.start_transmit    = 1'b1;
            a.slave_address_out = r.slave_address;
        end else if (r.command == CMD_TX_READY) begin
            case (seq_phase)
                PH_ADDR: begin
                    a.tx_valid = 1'b1;
                    if (!addr_low_next) begin
                        a.tx_byte     = reg_addr_held[15:8];
                        addr_low_next = 1'b1;
                    end else begin
                        a.tx_byte = reg_addr_held[7:0];
                        seq_phase = (bytes_to_read != 0) ? PH_SWRX : PH_WDATA;
                    end
                end
                PH_SWRX: begin
                    a.repeated_start_rx = 1'b1;
                    seq_phase = PH_RDATA;
                    if (bytes_to_read == 1) a.stop_request = 1'b1;
                end
                PH_WDATA: begin
                    if (bytes_to_write != 0) begin
                        a.tx_valid     = 1'b1;
                        a.tx_byte      = write_low_next ? payload_held[7:0] : payload_held[15:8];
                        write_low_next = ~write_low_next;
                        bytes_to_write = bytes_to_write - 1'b1;
                    end else begin
                        a.stop_request = 1'b1;
                        a.done_res     = 1'b1;
                        seq_phase      = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end else if (seq_phase == PH_RDATA) begin
            if (bytes_to_read != 0) begin
                a.rx_valid    = 1'b1;
                a.rx_byte_out = r.rx_data;
                a.rx_position = read_pos[5:0];
                read_pos      = read_pos + 1'b1;
                bytes_to_read = bytes_to_read - 1'b1;
            end
            // The stop goes out while one byte is still on its way.
            if (bytes_to_read == 1) begin
                a.stop_request = 1'b1;
            end else if (bytes_to_read == 0) begin
                a.done_res = 1'b1;
                seq_phase  = PH_IDLE;
            end
        end
        a.busy_res = (seq_phase != PH_IDLE);
        return a;
    endfunction

    function automatic seq_req_t random_req(input cmd_t c);
        seq_req_t r;
        r.command          = c;
        r.slave_address    = 7'($urandom_range(0, 127));
        r.register_address = 16'($urandom_range(0, 65535));
        r.byte_count       = 7'($urandom_range(0, 127));
        r.write_value      = 16'($urandom_range(0, 65535));
        r.rx_data          = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic add_start(input cmd_t c, input logic [6:0] slv, input logic [15:0] ra,
                             input logic [6:0] cnt, input logic [15:0] val);
        seq_req_t r;
        r = random_req(c);
        r.slave_address    = slv;
        r.register_address = ra;
        r.byte_count       = cnt;
        r.write_value      = val;
        pending_reqs.push_back(r);
    endtask

    task automatic add_events(input cmd_t c, input int n);
        for (int i = 0; i < n; i++) pending_reqs.push_back(random_req(c));
    endtask

    // One transaction with random content; some get cut short or salted with stray requests.
    task automatic add_transaction(output int n_useful);
        seq_req_t r;
        bit       is_read;
        int       pick, cnt, eff, n_tx, n_total, cut;
        is_read = $urandom_range(0, 1);
        pick    = $urandom_range(0, 99);
        if (is_read) begin
            cnt = (pick < 5) ? $urandom_range(64, 127) : (pick < 12) ? 0 : $urandom_range(1, 6);
            eff = (cnt > READ_LIMIT) ? READ_LIMIT : cnt;
            n_tx = 3;
        end else begin
            cnt = (pick < 10) ? $urandom_range(3, 127) : $urandom_range(0, 2);
            eff = (cnt > 2) ? 2 : cnt;
            n_tx = 3 + eff;
        end
        r = random_req(is_read ? CMD_START_READ : CMD_START_WRITE);
        r.byte_count = 7'(cnt);
        pending_reqs.push_back(r);
        n_useful = 1;
        n_total = n_tx + (is_read ? eff : 0);
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, n_total - 1) : n_total;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 99) < 6)
                pending_reqs.push_back(random_req(cmd_t'($urandom_range(0, 3))));
            pending_reqs.push_back(random_req((i < n_tx) ? CMD_TX_READY : CMD_RX_BYTE));
            n_useful++;
        end
    endtask

    task automatic add_random_traffic(input int target);
        int got, n;
        got = 0;
        while (got < target) begin
            add_transaction(n);
            got += n;
        end
    endtask

    task automatic add_directed();
        add_events(CMD_TX_READY, 1);                               // ignored while idle
        add_events(CMD_RX_BYTE, 1);                                // ignored while idle
        add_start(CMD_START_READ, 7'h7f, 16'hffff, 7'd0, 16'h0000); // read of nothing
        add_events(CMD_TX_READY, 3);
        add_start(CMD_START_WRITE, 7'h00, 16'h0000, 7'd1, 16'hffff); // single payload byte
        add_events(CMD_TX_READY, 4);
        add_start(CMD_START_WRITE, 7'h2a, 16'ha55a, 7'd127, 16'h1234);
        add_events(CMD_TX_READY, 1);
        // A new start drops the write above halfway through its address.
        add_start(CMD_START_READ, 7'h55, 16'h5aa5, 7'd1, 16'hffff);
        add_events(CMD_TX_READY, 4);                               // last one lands in read data
        pending_reqs.push_back(random_req(CMD_RX_BYTE));
        pending_reqs[$].rx_data = 8'hff;
        add_events(CMD_RX_BYTE, 1);                                // back to idle, ignored
        add_start(CMD_START_WRITE, 7'h01, 16'h8001, 7'd2, 16'h00ff);
        add_events(CMD_TX_READY, 5);
    endtask

    // Driver: a request stays on the bus until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                bus_actions_due.push_back(predict_bus_action(req_on_bus));
                n_requests++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_next     = pending_reqs.pop_front();
                    req_on_bus   = req_next;
                    s_axis_tdata <= {2'b00, req_next.rx_data, req_next.write_value,
                                     req_next.byte_count, req_next.register_address,
                                     req_next.slave_address};
                    s_axis_tuser <= req_next.command;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    result_t got_action;
    result_t want_action;

    // Monitor: checks each result and drives the receiver's ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_action = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                n_results++;
                if (got_action.start_transmit) n_starts++;
                if (got_action.rx_valid) n_rx_bytes++;
                if (got_action.done_res) n_completed++;
                if (bus_actions_due.size() == 0) begin
                    n_failures++;
                    if (n_failures <= REPORT_MAX)
                        $display("Result %0d arrived with nothing expected: %h",
                                 n_results, got_action);
                end else begin
                    want_action = bus_actions_due.pop_front();
                    if (got_action !== want_action) begin
                        n_failures++;
                        if (n_failures <= REPORT_MAX)
                            $display("Result %0d mismatch: expected %h, got %h",
                                     n_results, want_action, got_action);
                    end
                end
            end
            if (hold_off_req) begin
                hold_off_req  = 1'b0;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any request or result moving.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAIL i2c_master_register_sequencer");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            @(negedge aclk);
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (p == 0) begin
                add_directed();
                // Receiver holds off while requests keep coming, so the block backs up.
                hold_off_req = 1'b1;
            end
            add_random_traffic(175);
            while (pending_reqs.size() != 0) @(posedge aclk);
        end
        while (s_axis_tvalid || bus_actions_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Covered %0d requests and %0d results: %0d starts, %0d bytes received,",
                 n_requests, n_results, n_starts, n_rx_bytes);
        $display("%0d completed transactions, %0d failures.", n_completed, n_failures);
        if (n_failures == 0 && bus_actions_due.size() == 0) begin
            $display("PASS i2c_master_register_sequencer");
        end else begin
            $display("FAIL i2c_master_register_sequencer");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/i2cseq_pkg.sv
design/i2cseq_step.sv
design/i2cseq_out_reg.sv
design/i2c_master_register_sequencer.sv
test/i2c_master_register_sequencer_tb.sv
